### src/irm_pkg.sv
`timescale 1ns / 1ps

package irm_pkg;

   localparam int MAX_PACKET_BYTES = 1024;
   localparam int OFFSET_LIMIT = (MAX_PACKET_BYTES < 2047) ? MAX_PACKET_BYTES : 2047;
   localparam int OFFSET_W = 11;

   localparam int WORD_BYTES = 4;
   localparam int ICMP_HEADER_BYTES = 8;
   localparam int ID_OFFSET = 4;
   localparam int SEQ_OFFSET = 6;
   localparam int SOURCE_FIRST = 12;
   localparam int SOURCE_LAST = 15;

   localparam logic [7:0] MSG_ECHO_REPLY = 8'd0;
   localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ID = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_SEQ = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_TICK = 2'd2;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_TOO_SHORT = 2'd1,
      STATUS_OTHER_TYPE = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_ECHO_REPLY = 2'd1,
      KIND_TIME_EXCEEDED = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] expected_id;
      logic [15:0] expected_seq;
      logic [31:0] send_tick;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      kind_type    reply_kind;
      logic [31:0] source_address;
      logic [31:0] round_trip;
   } result_type;

endpackage

### src/irm_csr.sv
`timescale 1ns / 1ps

module irm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [irm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [irm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output irm_pkg::cfg_type                  cfg
);

   irm_pkg::cfg_type cfg_ff;
   irm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            irm_pkg::CSR_EXPECTED_ID:  cfg_in.expected_id = csr_write_data[15:0];
            irm_pkg::CSR_EXPECTED_SEQ: cfg_in.expected_seq = csr_write_data[15:0];
            irm_pkg::CSR_SEND_TICK:    cfg_in.send_tick = csr_write_data[31:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/irm_parser.sv
`timescale 1ns / 1ps

module irm_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            packet_byte,
   input  logic                  last_byte,
   input  logic [31:0]           now_tick,
   input  irm_pkg::cfg_type      cfg,
   output logic                  result_valid,
   output irm_pkg::result_type   result
);

   localparam int W = irm_pkg::OFFSET_W;

   logic [W-1:0]  offset_ff, offset_in;
   logic [5:0]    outer_ff, outer_in;
   logic [7:0]    type_ff, type_in;
   logic [5:0]    inner_ff, inner_in;
   logic [15:0]   id_ff, id_in;
   logic [15:0]   seq_ff, seq_in;
   logic [31:0]   source_ff, source_in;
   logic          seen_ff, seen_in;

   logic [W-1:0]  pos;
   logic          active;
   logic [5:0]    outer_upd;
   logic [W-1:0]  hdr;
   logic [7:0]    type_upd;
   logic [5:0]    inner_upd;
   logic [31:0]   source_upd;
   logic          base_ok;
   logic [W-1:0]  base;
   logic          id_hit, seq_hit, seen_hit;
   logic [15:0]   id_upd, seq_upd;
   logic [W-1:0]  len;
   logic          type_seen;
   irm_pkg::kind_type   kind;
   irm_pkg::status_type status;

   assign pos = offset_ff;
   assign active = pos < W'(irm_pkg::OFFSET_LIMIT);

   always_comb begin
      outer_upd = (pos == '0) ? {packet_byte[3:0], 2'b00} : outer_ff;
      hdr = W'(outer_upd);
      source_upd = (pos >= W'(irm_pkg::SOURCE_FIRST) && pos <= W'(irm_pkg::SOURCE_LAST))
                   ? {source_ff[23:0], packet_byte} : source_ff;
      type_upd = (pos == hdr) ? packet_byte : type_ff;
      inner_upd = (pos > hdr && type_upd == irm_pkg::ICMP_TIME_EXCEEDED
                   && pos == hdr + W'(irm_pkg::ICMP_HEADER_BYTES))
                  ? {packet_byte[3:0], 2'b00} : inner_ff;

      base_ok = 1'b0;
      base = hdr;
      priority if (type_upd == irm_pkg::MSG_ECHO_REPLY) begin
         base_ok = 1'b1;
         base = hdr;
      end else if (type_upd == irm_pkg::ICMP_TIME_EXCEEDED
                   && pos > hdr + W'(irm_pkg::ICMP_HEADER_BYTES)) begin
         base_ok = 1'b1;
         base = hdr + W'(irm_pkg::ICMP_HEADER_BYTES) + W'(inner_upd);
      end else begin
         base_ok = 1'b0;
         base = hdr;
      end

      id_hit = (pos > hdr) && base_ok &&
               (pos == base + W'(irm_pkg::ID_OFFSET) ||
                pos == base + W'(irm_pkg::ID_OFFSET + 1));
      seq_hit = (pos > hdr) && base_ok &&
                (pos == base + W'(irm_pkg::SEQ_OFFSET) ||
                 pos == base + W'(irm_pkg::SEQ_OFFSET + 1));
      seen_hit = (pos > hdr) && base_ok && (pos == base + W'(irm_pkg::SEQ_OFFSET + 1));
      id_upd = id_hit ? {id_ff[7:0], packet_byte} : id_ff;
      seq_upd = seq_hit ? {seq_ff[7:0], packet_byte} : seq_ff;

      if (active) begin
         offset_in = pos + W'(1);
         outer_in = outer_upd;
         type_in = type_upd;
         inner_in = inner_upd;
         id_in = id_upd;
         seq_in = seq_upd;
         source_in = source_upd;
         seen_in = seen_ff | seen_hit;
      end else begin
         offset_in = offset_ff;
         outer_in = outer_ff;
         type_in = type_ff;
         inner_in = inner_ff;
         id_in = id_ff;
         seq_in = seq_ff;
         source_in = source_ff;
         seen_in = seen_ff;
      end
   end

   always_comb begin
      len = offset_in;
      type_seen = len > W'(outer_in);
      kind = irm_pkg::KIND_OTHER;
      if (type_seen && type_in == irm_pkg::MSG_ECHO_REPLY) begin
         kind = irm_pkg::KIND_ECHO_REPLY;
      end else if (type_seen && type_in == irm_pkg::ICMP_TIME_EXCEEDED) begin
         kind = irm_pkg::KIND_TIME_EXCEEDED;
      end
      priority if (len < W'(outer_in) + W'(irm_pkg::ICMP_HEADER_BYTES)) begin
         status = irm_pkg::STATUS_TOO_SHORT;
      end else if (kind == irm_pkg::KIND_OTHER) begin
         status = irm_pkg::STATUS_OTHER_TYPE;
      end else if (!seen_in) begin
         status = irm_pkg::STATUS_TOO_SHORT;
      end else if (id_in != cfg.expected_id || seq_in != cfg.expected_seq) begin
         status = irm_pkg::STATUS_MISMATCH;
      end else begin
         status = irm_pkg::STATUS_ACCEPTED;
      end
      result.status = status;
      result.reply_kind = kind;
      result.source_address = source_in;
      result.round_trip = now_tick - cfg.send_tick;
   end

   assign result_valid = accept && last_byte;

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         offset_ff <= '0;
         outer_ff <= '0;
         type_ff <= '0;
         inner_ff <= '0;
         id_ff <= '0;
         seq_ff <= '0;
         source_ff <= '0;
         seen_ff <= 1'b0;
      end else if (accept) begin
         offset_ff <= offset_in;
         outer_ff <= outer_in;
         type_ff <= type_in;
         inner_ff <= inner_in;
         id_ff <= id_in;
         seq_ff <= seq_in;
         source_ff <= source_in;
         seen_ff <= seen_in;
      end
   end

endmodule

### src/irm_out_buf.sv
`timescale 1ns / 1ps

module irm_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  irm_pkg::result_type   push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output irm_pkg::result_type   out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   irm_pkg::result_type  out_data_ff, out_data_in;
   irm_pkg::result_type  skid_data_ff, skid_data_in;
   logic                 out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

endmodule

### src/icmp_reply_matcher_top.sv
`timescale 1ns / 1ps
// the result of a packet is registered in the output buffer after its last byte transaction
// throughput: one byte per cycle while req_stall is low; each byte passes one compare and capture stage
// a two-entry output buffer holds results; req_stall rises only when both are full
// reset (synchronous, active high) clears registers, packet state and both result slots

module icmp_reply_matcher_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_packet_byte,
   input  logic                             req_last_byte,
   input  logic [31:0]                      req_now_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [1:0]                       rsp_reply_kind,
   output logic [31:0]                      rsp_source_address,
   output logic [31:0]                      rsp_round_trip,
   input  logic                             csr_write_enable,
   input  logic [irm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [irm_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   irm_pkg::cfg_type     cfg;
   irm_pkg::result_type  result;
   irm_pkg::result_type  out_data;
   logic                 result_valid;
   logic                 full;
   logic                 accept;

   assign req_stall = full;
   assign accept = req_valid && !full;

   irm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   irm_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .packet_byte  (req_packet_byte),
      .last_byte    (req_last_byte),
      .now_tick     (req_now_tick),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   irm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_status = out_data.status;
   assign rsp_reply_kind = out_data.reply_kind;
   assign rsp_source_address = out_data.source_address;
   assign rsp_round_trip = out_data.round_trip;

endmodule

### dv/icmp_reply_checker.sv
`timescale 1ns / 1ps

module icmp_reply_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [7:0]                       req_packet_byte,
   input  logic                             req_last_byte,
   input  logic [31:0]                      req_now_tick,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [1:0]                       rsp_status,
   input  logic [1:0]                       rsp_reply_kind,
   input  logic [31:0]                      rsp_source_address,
   input  logic [31:0]                      rsp_round_trip,
   input  logic                             csr_write_enable,
   input  logic [irm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [irm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                               mismatch_count,
   output int                               replies_pending,
   output int                               replies_checked,
   output int                               replies_accepted
);

   irm_pkg::cfg_type     probe_cfg;
   irm_pkg::result_type  expected_replies[$];

   // per-packet parse state
   int unsigned byte_pos;
   int unsigned outer_len;
   int unsigned inner_len;
   logic [7:0]  msg_type;
   logic [15:0] got_id;
   logic [15:0] got_seq;
   logic [31:0] got_src;
   logic        fields_done;

   initial begin
      mismatch_count = 0;
      replies_pending = 0;
      replies_checked = 0;
      replies_accepted = 0;
   end

   task automatic clear_packet_state();
      byte_pos = 0;
      outer_len = 0;
      inner_len = 0;
      msg_type = '0;
      got_id = '0;
      got_seq = '0;
      got_src = '0;
      fields_done = 1'b0;
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      int unsigned h;
      int unsigned base;
      bit          known;
      known = 1'b1;
      base = 0;
      if (byte_pos == 0)
         outer_len = b[3:0] * irm_pkg::WORD_BYTES;
      h = outer_len;
      if (byte_pos >= irm_pkg::SOURCE_FIRST && byte_pos <= irm_pkg::SOURCE_LAST)
         got_src = {got_src[23:0], b};
      if (byte_pos == h)
         msg_type = b;
      if (byte_pos > h && msg_type == irm_pkg::ICMP_TIME_EXCEEDED &&
          byte_pos == h + irm_pkg::ICMP_HEADER_BYTES)
         inner_len = b[3:0] * irm_pkg::WORD_BYTES;
      if (byte_pos <= h)
         known = 1'b0;
      else if (msg_type == irm_pkg::MSG_ECHO_REPLY)
         base = h;
      else if (msg_type == irm_pkg::ICMP_TIME_EXCEEDED &&
               byte_pos > h + irm_pkg::ICMP_HEADER_BYTES)
         base = h + irm_pkg::ICMP_HEADER_BYTES + inner_len;
      else
         known = 1'b0;
      if (known) begin
         if (byte_pos == base + irm_pkg::ID_OFFSET || byte_pos == base + irm_pkg::ID_OFFSET + 1)
            got_id = {got_id[7:0], b};
         if (byte_pos == base + irm_pkg::SEQ_OFFSET ||
             byte_pos == base + irm_pkg::SEQ_OFFSET + 1)
            got_seq = {got_seq[7:0], b};
         if (byte_pos == base + irm_pkg::SEQ_OFFSET + 1)
            fields_done = 1'b1;
      end
   endtask

   function automatic irm_pkg::result_type close_packet(input logic [31:0] now);
      irm_pkg::result_type r;
      bit                  type_seen;
      type_seen = byte_pos > outer_len;
      r.reply_kind = irm_pkg::KIND_OTHER;
      if (type_seen && msg_type == irm_pkg::MSG_ECHO_REPLY)
         r.reply_kind = irm_pkg::KIND_ECHO_REPLY;
      else if (type_seen && msg_type == irm_pkg::ICMP_TIME_EXCEEDED)
         r.reply_kind = irm_pkg::KIND_TIME_EXCEEDED;
      if (byte_pos < outer_len + irm_pkg::ICMP_HEADER_BYTES)
         r.status = irm_pkg::STATUS_TOO_SHORT;
      else if (r.reply_kind == irm_pkg::KIND_OTHER)
         r.status = irm_pkg::STATUS_OTHER_TYPE;
      else if (!fields_done)
         r.status = irm_pkg::STATUS_TOO_SHORT;
      else if (got_id != probe_cfg.expected_id || got_seq != probe_cfg.expected_seq)
         r.status = irm_pkg::STATUS_MISMATCH;
      else
         r.status = irm_pkg::STATUS_ACCEPTED;
      r.source_address = got_src;
      r.round_trip = now - probe_cfg.send_tick;
      return r;
   endfunction

   always @(posedge clock) begin
      irm_pkg::result_type seen;
      irm_pkg::result_type want;
      string               diffs;
      if (reset) begin
         probe_cfg = '0;
         clear_packet_state();
         expected_replies.delete();
      end else begin
         // replies are registered after their last byte, so check them first
         if (rsp_valid && !rsp_stall) begin
            seen.status = irm_pkg::status_type'(rsp_status);
            seen.reply_kind = irm_pkg::kind_type'(rsp_reply_kind);
            seen.source_address = rsp_source_address;
            seen.round_trip = rsp_round_trip;
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("reply with no packet pending: status %0d kind %0d",
                                         rsp_status, rsp_reply_kind));
            end else begin
               want = expected_replies.pop_front();
               diffs = "";
               if (seen.status !== want.status)
                  diffs = {diffs, $sformatf(" status %0d/%0d", seen.status, want.status)};
               if (seen.reply_kind !== want.reply_kind)
                  diffs = {diffs, $sformatf(" kind %0d/%0d", seen.reply_kind, want.reply_kind)};
               if (seen.source_address !== want.source_address)
                  diffs = {diffs, $sformatf(" source %h/%h", seen.source_address,
                                            want.source_address)};
               if (seen.round_trip !== want.round_trip)
                  diffs = {diffs, $sformatf(" round_trip %h/%h", seen.round_trip,
                                            want.round_trip)};
               if (diffs != "")
                  report_mismatch($sformatf("reply %0d got/exp:%s", replies_checked, diffs));
               replies_checked++;
               if (want.status == irm_pkg::STATUS_ACCEPTED)
                  replies_accepted++;
            end
         end
         if (req_valid && !req_stall) begin
            if (byte_pos < irm_pkg::OFFSET_LIMIT) begin
               parse_byte(req_packet_byte);
               byte_pos++;
            end
            if (req_last_byte) begin
               expected_replies.push_back(close_packet(req_now_tick));
               clear_packet_state();
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               irm_pkg::CSR_EXPECTED_ID: probe_cfg.expected_id = csr_write_data[15:0];
               irm_pkg::CSR_EXPECTED_SEQ: probe_cfg.expected_seq = csr_write_data[15:0];
               irm_pkg::CSR_SEND_TICK: probe_cfg.send_tick = csr_write_data[31:0];
               default: ;
            endcase
         end
      end
      replies_pending = expected_replies.size();
   end

endmodule

### dv/tb_icmp_reply_matcher_top.sv
`timescale 1ns / 1ps

module tb_icmp_reply_matcher_top;

   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES = 4;
   localparam int PHASE_BYTES = 20;
   localparam int HOLD_PACKETS = 20;
   localparam logic [irm_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [7:0] MSG_ECHO_REQUEST = 8'd8;
   localparam logic [7:0] ICMP_DEST_UNREACHABLE = 8'd3;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [7:0]                       req_packet_byte;
   logic                             req_last_byte;
   logic [31:0]                      req_now_tick;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [1:0]                       rsp_status;
   logic [1:0]                       rsp_reply_kind;
   logic [31:0]                      rsp_source_address;
   logic [31:0]                      rsp_round_trip;
   logic                             csr_write_enable;
   logic [irm_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [irm_pkg::CSR_DATA_W-1:0]   csr_write_data;

   int mismatch_count;
   int replies_pending;
   int replies_checked;
   int replies_accepted;

   logic [7:0]  pkt_bytes[$];
   logic [15:0] cur_id;
   logic [15:0] cur_seq;
   bit          no_idle;
   bit          hold_request;
   int          bytes_sent;
   int          packets_sent;
   int          settings_used;
   int          idle_watch;

   icmp_reply_matcher_top u_dut (.*);

   icmp_reply_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_packet_byte    (req_packet_byte),
      .req_last_byte      (req_last_byte),
      .req_now_tick       (req_now_tick),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_source_address (rsp_source_address),
      .rsp_round_trip     (rsp_round_trip),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .replies_pending    (replies_pending),
      .replies_checked    (replies_checked),
      .replies_accepted   (replies_accepted)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_watch <= 0;
      else
         idle_watch <= idle_watch + 1;
      if (idle_watch >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_watch);
         $display("icmp_reply_matcher_top test failed");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < 9);
         end
      end
   end

   task automatic put_reg(input logic [irm_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [irm_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] id, input logic [15:0] seq,
                               input logic [31:0] tick);
      cur_id = id;
      cur_seq = seq;
      put_reg(irm_pkg::CSR_EXPECTED_ID, {16'($urandom()), id});
      put_reg(irm_pkg::CSR_EXPECTED_SEQ, {16'($urandom()), seq});
      put_reg(irm_pkg::CSR_SEND_TICK, tick);
      put_reg(CSR_SPARE, $urandom());
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!no_idle && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_packet_byte <= b;
      req_last_byte <= last;
      req_now_tick <= $urandom();
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt_bytes[i])
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
      packets_sent++;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // fill < 0 gives random bytes
   task automatic build_noise(input int len, input int fill);
      pkt_bytes.delete();
      repeat (len)
         pkt_bytes.push_back((fill < 0) ? 8'($urandom()) : 8'(fill));
   endtask

   // keep > 0 truncates the packet to that many bytes
   task automatic build_reply(input logic [7:0] icmp_type, input logic [3:0] ihl,
                              input logic [3:0] inner_ihl, input bit id_ok, input bit seq_ok,
                              input int extra, input int keep);
      int          h;
      int          base;
      logic [15:0] id_word;
      logic [15:0] seq_word;
      h = ihl * irm_pkg::WORD_BYTES;
      base = (icmp_type == irm_pkg::ICMP_TIME_EXCEEDED) ?
             h + irm_pkg::ICMP_HEADER_BYTES + inner_ihl * irm_pkg::WORD_BYTES : h;
      id_word = id_ok ? cur_id : cur_id ^ (16'd1 << $urandom_range(0, 15));
      seq_word = seq_ok ? cur_seq : cur_seq ^ (16'd1 << $urandom_range(0, 15));
      build_noise(base + irm_pkg::ICMP_HEADER_BYTES + extra, -1);
      pkt_bytes[0] = {4'h4, ihl};
      pkt_bytes[h] = icmp_type;
      if (icmp_type == irm_pkg::ICMP_TIME_EXCEEDED) begin
         pkt_bytes[h + irm_pkg::ICMP_HEADER_BYTES] = {4'h4, inner_ihl};
         if (inner_ihl != 0)
            pkt_bytes[base] = MSG_ECHO_REQUEST;
      end
      pkt_bytes[base + irm_pkg::ID_OFFSET] = id_word[15:8];
      pkt_bytes[base + irm_pkg::ID_OFFSET + 1] = id_word[7:0];
      pkt_bytes[base + irm_pkg::SEQ_OFFSET] = seq_word[15:8];
      pkt_bytes[base + irm_pkg::SEQ_OFFSET + 1] = seq_word[7:0];
      while (keep > 0 && pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
   endtask

   task automatic build_random_packet();
      int         pick;
      logic [3:0] ihl;
      logic [3:0] inner;
      logic [7:0] other;
      pick = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'd5;
      inner = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'd5;
      other = 8'($urandom_range(1, 255));
      if (other == irm_pkg::ICMP_TIME_EXCEEDED)
         other = ICMP_DEST_UNREACHABLE;
      if (pick < 40)
         build_reply(irm_pkg::MSG_ECHO_REPLY, ihl, inner, $urandom_range(0, 4) != 0,
                     $urandom_range(0, 4) != 0, $urandom_range(0, 12), 0);
      else if (pick < 70)
         build_reply(irm_pkg::ICMP_TIME_EXCEEDED, ihl, inner, $urandom_range(0, 4) != 0,
                     $urandom_range(0, 4) != 0, $urandom_range(0, 12), 0);
      else if (pick < 80)
         build_reply(other, ihl, inner, 1'b1, 1'b1, $urandom_range(0, 12), 0);
      else if (pick < 90)
         build_reply(pick[0] ? irm_pkg::MSG_ECHO_REPLY : irm_pkg::ICMP_TIME_EXCEEDED, ihl,
                     inner, 1'b1, 1'b1, 0, $urandom_range(1, 40));
      else
         build_noise($urandom_range(1, 40), -1);
   endtask

   initial begin
      int phase_start;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_packet_byte <= '0;
      req_last_byte <= 1'b0;
      req_now_tick <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= irm_pkg::CSR_EXPECTED_ID;
      csr_write_data <= '0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      bytes_sent = 0;
      packets_sent = 0;
      settings_used = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      program_regs(16'h1234, 16'hABCD, 32'd100);

      // directed packets
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd5, 4'd5, 1'b1, 1'b1, 4, 0); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd5, 4'd5, 1'b0, 1'b1, 0, 0); send_packet();
      build_reply(irm_pkg::ICMP_TIME_EXCEEDED, 4'd5, 4'd5, 1'b1, 1'b1, 0, 0); send_packet();
      build_reply(irm_pkg::ICMP_TIME_EXCEEDED, 4'd5, 4'd5, 1'b1, 1'b0, 0, 0); send_packet();
      build_reply(ICMP_DEST_UNREACHABLE, 4'd5, 4'd5, 1'b1, 1'b1, 0, 0); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd5, 4'd5, 1'b1, 1'b1, 0, 27); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd5, 4'd5, 1'b1, 1'b1, 0, 21); send_packet();
      build_reply(irm_pkg::ICMP_TIME_EXCEEDED, 4'd5, 4'd5, 1'b1, 1'b1, 0, 54); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd5, 4'd5, 1'b1, 1'b1, 0, 1); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd5, 4'd5, 1'b1, 1'b1, 0, 14); send_packet();
      // odd header lengths back to back with no idling on either side
      no_idle = 1'b1;
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd15, 4'd5, 1'b1, 1'b1, 2, 0); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd0, 4'd5, 1'b1, 1'b1, 3, 0); send_packet();
      build_reply(irm_pkg::MSG_ECHO_REPLY, 4'd2, 4'd5, 1'b1, 1'b1, 6, 0); send_packet();
      build_reply(irm_pkg::ICMP_TIME_EXCEEDED, 4'd5, 4'd0, 1'b1, 1'b1, 0, 0); send_packet();
      build_reply(irm_pkg::ICMP_TIME_EXCEEDED, 4'd5, 4'd15, 1'b1, 1'b1, 0, 0); send_packet();
      build_reply(irm_pkg::ICMP_TIME_EXCEEDED, 4'd1, 4'd5, 1'b1, 1'b1, 4, 0); send_packet();
      build_noise(12, 8'h00); send_packet();
      build_noise(10, 8'hFF); send_packet();
      drain_replies();
      no_idle = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_regs(16'h0000, 16'h0000, 32'h0000_0000);
            1: program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
            default: program_regs(16'($urandom()), 16'($urandom()), $urandom());
         endcase
         no_idle = (phase == 3);
         if (phase == 2) begin
            // receiver holds off while short packets keep coming, so the input backs up
            hold_request = 1'b1;
            repeat (HOLD_PACKETS) begin
               build_noise($urandom_range(1, 3), -1);
               send_packet();
            end
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_random_packet();
            send_packet();
         end
         drain_replies();
      end

      $display("summary: %0d packets (%0d bytes) over %0d register settings, incl. hold-off",
               packets_sent, bytes_sent, settings_used);
      $display("summary: %0d replies checked, %0d accepted, %0d mismatches",
               replies_checked, replies_accepted, mismatch_count);
      if (mismatch_count == 0)
         $display("icmp_reply_matcher_top test passed");
      else
         $display("icmp_reply_matcher_top test failed");
      $finish;
   end

endmodule

### files.f
src/irm_pkg.sv
src/irm_csr.sv
src/irm_parser.sv
src/irm_out_buf.sv
src/icmp_reply_matcher_top.sv
dv/icmp_reply_checker.sv
dv/tb_icmp_reply_matcher_top.sv
